FILE: design/serial_command_gpio_bridge_assert.svh
// assertion macros for the serial command gpio bridge checker
`ifndef SERIAL_COMMAND_GPIO_BRIDGE_ASSERT_SVH
`define SERIAL_COMMAND_GPIO_BRIDGE_ASSERT_SVH

// property checked outside reset
`define SCGB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("serial_command_gpio_bridge assertion failed");

// property checked on every edge, reset included
`define SCGB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("serial_command_gpio_bridge assertion failed");

`endif

FILE: design/scgb_pkg.sv
// types and constants shared by the serial command gpio bridge
package scgb_pkg;

  typedef enum logic [3:0] {
    OP_TOGGLE    = 4'h0,
    OP_QUERY     = 4'h1,
    OP_READ      = 4'h2,
    OP_INVERT    = 4'h3,
    OP_WRITE_A   = 4'h4,
    OP_WRITE_B   = 4'h5,
    OP_SET_NZ    = 4'h6,
    OP_TOGGLE_NZ = 4'h7,
    OP_LOAD      = 4'h8,
    OP_AND       = 4'h9,
    OP_OR        = 4'hA,
    OP_XOR       = 4'hB
  } op_t;

  localparam logic [7:0] REPLY_HIGH    = 8'h68;
  localparam logic [7:0] REPLY_LOW     = 8'h6C;
  localparam logic [7:0] REPLY_UNKNOWN = 8'h00;
  localparam logic [7:0] LATCH_RESET   = 8'hFF;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] data;
    logic [7:0] pins;
  } job_t;

  typedef struct packed {
    logic [7:0] reply;
    logic [7:0] drive_a;
    logic [7:0] drive_b;
  } result_t;

endpackage

FILE: design/serial_command_gpio_bridge.sv
// top level of the serial command gpio bridge
//
// input queue side: push an item (rx_byte with the sampled port_a_pins and
// port_b_pins) while full is low. bytes alternate command then data; the
// command byte gives no result, the data byte gives exactly one.
// result queue side: while empty is low the oldest result (reply_byte,
// port_a_drive, port_b_drive) is on the ports; pop takes it.
// one item is accepted every cycle as long as the job queue has room.
// a data byte's job enters the job queue at its accepting edge. the back end
// applies one job per cycle to the port latches while the result queue has
// room, writing each result into the result queue, where it is then visible;
// a job waits in the job queue until those ahead of it have been applied.
// when pop is held low, results collect in the result queue, then jobs in
// the job queue, and full rises once the job queue holds JOB_DEPTH jobs.
// reset (rst, synchronous) empties both queues, expects a command byte next
// and sets both port latches to all high.
module serial_command_gpio_bridge #(
  parameter int JOB_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic [7:0] port_a_pins,
  input  logic [7:0] port_b_pins,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] reply_byte,
  output logic [7:0] port_a_drive,
  output logic [7:0] port_b_drive
);

  localparam int JOB_W = $bits(scgb_pkg::job_t);
  localparam int RES_W = $bits(scgb_pkg::result_t);

  logic              accept;
  logic              job_push;
  scgb_pkg::job_t    job_in;
  scgb_pkg::job_t    job_out;
  logic              job_empty;
  logic              job_pop;
  logic              res_full;
  logic              res_push;
  scgb_pkg::result_t res_in;
  scgb_pkg::result_t res_out;

  assign accept = push && !full;

  scgb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .port_a_pins (port_a_pins),
    .port_b_pins (port_b_pins),
    .job_push    (job_push),
    .job         (job_in)
  );

  scgb_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  scgb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  scgb_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign reply_byte   = res_out.reply;
  assign port_a_drive = res_out.drive_a;
  assign port_b_drive = res_out.drive_b;

endmodule

FILE: design/scgb_fifo.sv
// small register queue with first-word fall-through read
module scgb_fifo #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: design/scgb_front.sv
// front end: pairs command and data bytes into jobs
module scgb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       port_a_pins,
  input  logic [7:0]       port_b_pins,
  output logic             job_push,
  output scgb_pkg::job_t   job
);

  logic       expect_data;
  logic [7:0] held_command;

  assign job_push  = accept && expect_data;
  assign job.cmd   = held_command;
  assign job.data  = rx_byte;
  assign job.pins  = held_command[3] ? port_b_pins : port_a_pins;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_data  <= 1'b0;
      held_command <= '0;
    end else if (accept) begin
      expect_data <= !expect_data;
      if (!expect_data) begin
        held_command <= rx_byte;
      end
    end
  end

endmodule

FILE: design/scgb_back.sv
// back end: applies jobs to the port latches and builds results
module scgb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  scgb_pkg::job_t    job,
  output logic              job_pop,
  input  logic              res_full,
  output logic              res_push,
  output scgb_pkg::result_t res
);

  logic            [7:0] port_a_latch;
  logic            [7:0] port_b_latch;
  logic            [7:0] port_a_next;
  logic            [7:0] port_b_next;
  logic            [7:0] mask;
  logic            [7:0] cur;
  logic            [7:0] new_p;
  logic            [7:0] reply;
  logic                  sel_b;
  logic                  data_nz;
  logic                  run;
  scgb_pkg::op_t         op;

  assign run      = job_valid && !res_full;
  assign job_pop  = run;
  assign res_push = run;

  always_comb begin
    op      = scgb_pkg::op_t'(job.cmd[7:4]);
    sel_b   = job.cmd[3];
    mask    = 8'b1 << job.cmd[2:0];
    cur     = sel_b ? port_b_latch : port_a_latch;
    data_nz = (job.data != 8'h00);
    new_p   = cur;
    reply   = scgb_pkg::REPLY_UNKNOWN;
    unique case (op)
      scgb_pkg::OP_TOGGLE: begin
        new_p = cur ^ mask;
        reply = new_p;
      end
      scgb_pkg::OP_QUERY: begin
        reply = |(job.pins & mask) ? scgb_pkg::REPLY_HIGH : scgb_pkg::REPLY_LOW;
      end
      scgb_pkg::OP_READ: begin
        reply = job.pins;
      end
      scgb_pkg::OP_INVERT: begin
        new_p = ~cur;
        reply = new_p;
      end
      scgb_pkg::OP_WRITE_A, scgb_pkg::OP_WRITE_B: begin
        new_p = data_nz ? (cur | mask) : (cur & ~mask);
        reply = new_p;
      end
      scgb_pkg::OP_SET_NZ: begin
        new_p = data_nz ? (cur | mask) : cur;
        reply = new_p;
      end
      scgb_pkg::OP_TOGGLE_NZ: begin
        new_p = data_nz ? (cur ^ mask) : cur;
        reply = new_p;
      end
      scgb_pkg::OP_LOAD: begin
        new_p = job.data;
        reply = new_p;
      end
      scgb_pkg::OP_AND: begin
        new_p = cur & job.data;
        reply = new_p;
      end
      scgb_pkg::OP_OR: begin
        new_p = cur | job.data;
        reply = new_p;
      end
      scgb_pkg::OP_XOR: begin
        new_p = cur ^ job.data;
        reply = new_p;
      end
      default: begin
        new_p = cur;
        reply = scgb_pkg::REPLY_UNKNOWN;
      end
    endcase
    port_a_next = sel_b ? port_a_latch : new_p;
    port_b_next = sel_b ? new_p : port_b_latch;
  end

  assign res.reply   = reply;
  assign res.drive_a = port_a_next;
  assign res.drive_b = port_b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_a_latch <= scgb_pkg::LATCH_RESET;
      port_b_latch <= scgb_pkg::LATCH_RESET;
    end else if (run) begin
      port_a_latch <= port_a_next;
      port_b_latch <= port_b_next;
    end
  end

endmodule

FILE: design/scgb_checker.sv
// port-level checker for the serial command gpio bridge, with its bind
`include "serial_command_gpio_bridge_assert.svh"

module scgb_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] reply_byte,
  input logic [7:0] port_a_drive,
  input logic [7:0] port_b_drive
);

  logic       data_next;
  logic [7:0] outstanding;
  logic       in_take;
  logic       out_take;

  assign in_take  = push && !full;
  assign out_take = pop && !empty;

  // data items accepted whose results are not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      data_next   <= 1'b0;
      outstanding <= '0;
    end else begin
      if (in_take) begin
        data_next <= !data_next;
      end
      outstanding <= outstanding + 8'(in_take && data_next) - 8'(out_take);
    end
  end

  `SCGB_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> empty)
  `SCGB_ASSERT(a_no_spurious_result, clk, rst, !empty |-> (outstanding != 8'd0))
  `SCGB_ASSERT(a_full_needs_work, clk, rst, full |-> (outstanding != 8'd0))
  `SCGB_ASSERT(a_stalled_result_holds, clk, rst,
    (!empty && !pop) |=> (!empty && $stable(reply_byte) && $stable(port_a_drive)
      && $stable(port_b_drive)))

endmodule

bind serial_command_gpio_bridge scgb_checker u_scgb_checker (.*);

FILE: bench/tb_serial_command_gpio_bridge.sv
// testbench for the serial command gpio bridge: directed and random byte pairs, scored per item
`timescale 1ns / 100ps

module tb_serial_command_gpio_bridge;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] rx_byte;
  logic [7:0] port_a_pins;
  logic [7:0] port_b_pins;
  logic       empty;
  logic       pop;
  logic [7:0] reply_byte;
  logic [7:0] port_a_drive;
  logic [7:0] port_b_drive;

  // predicted bridge state
  logic       data_next = 1'b0;
  logic [7:0] held_cmd = 8'h00;
  logic [7:0] latch_a = scgb_pkg::LATCH_RESET;
  logic [7:0] latch_b = scgb_pkg::LATCH_RESET;

  scgb_pkg::result_t expected_results[$];
  scgb_pkg::result_t oldest;
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  int      stall_left = 0;
  bit      tx_steady = 1'b0;
  bit      rx_steady = 1'b0;
  bit      long_hold_req = 1'b0;

  serial_command_gpio_bridge u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .port_a_pins  (port_a_pins),
    .port_b_pins  (port_b_pins),
    .empty        (empty),
    .pop          (pop),
    .reply_byte   (reply_byte),
    .port_a_drive (port_a_drive),
    .port_b_drive (port_b_drive)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %02h want %02h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // advance the predicted bridge by one accepted byte
  task automatic apply_byte(input logic [7:0] rx, input logic [7:0] pins_a,
                            input logic [7:0] pins_b);
    logic [7:0] pin_bit;
    logic [7:0] port;
    logic [7:0] pins;
    logic [7:0] reply;
    scgb_pkg::result_t res;
    if (!data_next) begin
      held_cmd = rx;
      data_next = 1'b1;
      return;
    end
    data_next = 1'b0;
    pin_bit = 8'h01 << held_cmd[2:0];
    port = held_cmd[3] ? latch_b : latch_a;
    pins = held_cmd[3] ? pins_b : pins_a;
    reply = scgb_pkg::REPLY_UNKNOWN;
    case (held_cmd[7:4])
      scgb_pkg::OP_TOGGLE: begin
        port = port ^ pin_bit;
        reply = port;
      end
      scgb_pkg::OP_QUERY: begin
        reply = ((pins & pin_bit) != 8'h00) ? scgb_pkg::REPLY_HIGH
                                            : scgb_pkg::REPLY_LOW;
      end
      scgb_pkg::OP_READ: reply = pins;
      scgb_pkg::OP_INVERT: begin
        port = ~port;
        reply = port;
      end
      scgb_pkg::OP_WRITE_A, scgb_pkg::OP_WRITE_B: begin
        port = (rx == 8'h00) ? (port & ~pin_bit) : (port | pin_bit);
        reply = port;
      end
      scgb_pkg::OP_SET_NZ: begin
        if (rx != 8'h00) port = port | pin_bit;
        reply = port;
      end
      scgb_pkg::OP_TOGGLE_NZ: begin
        if (rx != 8'h00) port = port ^ pin_bit;
        reply = port;
      end
      scgb_pkg::OP_LOAD: begin
        port = rx;
        reply = port;
      end
      scgb_pkg::OP_AND: begin
        port = port & rx;
        reply = port;
      end
      scgb_pkg::OP_OR: begin
        port = port | rx;
        reply = port;
      end
      scgb_pkg::OP_XOR: begin
        port = port ^ rx;
        reply = port;
      end
      default: reply = scgb_pkg::REPLY_UNKNOWN;
    endcase
    if (held_cmd[3]) latch_b = port;
    else latch_a = port;
    res.reply = reply;
    res.drive_a = latch_a;
    res.drive_b = latch_b;
    expected_results.push_back(res);
  endtask

  // results are checked before the new byte is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("item with none expected, reply", reply_byte, 8'h00);
        end else begin
          oldest = expected_results.pop_front();
          if (reply_byte !== oldest.reply)
            report_mismatch("reply_byte", reply_byte, oldest.reply);
          if (port_a_drive !== oldest.drive_a)
            report_mismatch("port_a_drive", port_a_drive, oldest.drive_a);
          if (port_b_drive !== oldest.drive_b)
            report_mismatch("port_b_drive", port_b_drive, oldest.drive_b);
        end
      end
      if (push && !full) apply_byte(rx_byte, port_a_pins, port_b_pins);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && !rx_steady && $urandom_range(0, 99) < 30)
        stall_left = idle_len();
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [7:0] rx, input logic [7:0] pins_a,
                           input logic [7:0] pins_b);
    int gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= rx;
    port_a_pins <= pins_a;
    port_b_pins <= pins_b;
    do @(posedge clk); while (full);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01 << $urandom_range(0, 7);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] make_cmd(input logic [3:0] op, input bit sel_b,
                                          input int pin);
    return {op, sel_b, pin[2:0]};
  endfunction

  function automatic logic [7:0] rand_cmd();
    logic [3:0] op;
    if ($urandom_range(0, 99) < 10) op = 4'($urandom_range(12, 15));
    else op = 4'($urandom_range(0, 11));
    return make_cmd(op, 1'($urandom_range(0, 1)), $urandom_range(0, 7));
  endfunction

  task automatic send_pair(input logic [7:0] cmd, input logic [7:0] data,
                           input logic [7:0] pins_a, input logic [7:0] pins_b);
    send_item(cmd, rand_byte(), rand_byte());
    send_item(data, pins_a, pins_b);
  endtask

  task automatic send_random_pairs(input int count);
    repeat (count) send_pair(rand_cmd(), rand_byte(), rand_byte(), rand_byte());
  endtask

  // first let the last accepted item be predicted, then wait until no result is still expected
  task automatic wait_results_drained();
    push <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_each_operation();
    send_pair(make_cmd(scgb_pkg::OP_XOR, 1'b0, 0), 8'h00, 8'h00, 8'h00);
    send_pair(make_cmd(scgb_pkg::OP_LOAD, 1'b1, 5), 8'h00, 8'hFF, 8'hFF);
    send_pair(make_cmd(scgb_pkg::OP_TOGGLE, 1'b1, 7), 8'hFF, 8'h00, 8'h00);
    send_pair(make_cmd(scgb_pkg::OP_TOGGLE_NZ, 1'b0, 0), 8'h00, 8'hFF, 8'hFF);
    send_pair(make_cmd(scgb_pkg::OP_SET_NZ, 1'b1, 0), 8'hFF, 8'h00, 8'h00);
    send_pair(make_cmd(scgb_pkg::OP_WRITE_A, 1'b0, 7), 8'h00, 8'hFF, 8'hFF);
    send_pair(make_cmd(scgb_pkg::OP_WRITE_B, 1'b1, 3), 8'h80, 8'h00, 8'h00);
    send_pair(make_cmd(scgb_pkg::OP_INVERT, 1'b0, 2), 8'h55, 8'hFF, 8'hFF);
    send_pair(make_cmd(scgb_pkg::OP_AND, 1'b1, 1), 8'h0F, 8'h00, 8'h00);
    send_pair(make_cmd(scgb_pkg::OP_OR, 1'b0, 6), 8'h01, 8'h00, 8'h00);
    send_pair(make_cmd(scgb_pkg::OP_QUERY, 1'b1, 0), 8'hFF, 8'hFF, 8'hFE);
    send_pair(make_cmd(scgb_pkg::OP_READ, 1'b1, 4), 8'h00, 8'hFF, 8'h00);
    send_pair(make_cmd(4'hF, 1'b1, 7), 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_steady_stream();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_random_pairs(50);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_random_pairs();
    send_random_pairs(300);
  endtask

  task automatic test_result_backpressure();
    long_hold_req = 1'b1;
    tx_steady = 1'b1;
    send_random_pairs(30);
    tx_steady = 1'b0;
  endtask

  task automatic test_sender_pause();
    send_random_pairs(10);
    wait_results_drained();
    send_random_pairs(10);
    send_item(rand_cmd(), rand_byte(), rand_byte());
    wait_results_drained();
    send_item(rand_byte(), rand_byte(), rand_byte());
    send_random_pairs(9);
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    rx_byte = 8'h00;
    port_a_pins = 8'h00;
    port_b_pins = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_each_operation();
    test_steady_stream();
    test_random_pairs();
    test_result_backpressure();
    test_sender_pause();
    wait_results_drained();
    rx_steady = 1'b1;
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
